FILE: rtl/sbrua_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the block-sparse row union adder.
// No dependencies; sbrua_ctrl, sbrua_dp and the top level import this package.
package sbrua_pkg;

   localparam int COL_W   = 10;
   localparam int ELEM_W  = 4;
   localparam int VAL_W   = 32;
   localparam int BS_W    = 3;
   localparam int NC_W    = 11;
   localparam int POSO_W  = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = NC_W;

   localparam logic [1:0] CMD_A       = 2'd0;
   localparam logic [1:0] CMD_B       = 2'd1;
   localparam logic [1:0] CMD_ROW_END = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_ROW_END = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_RANGE  = 2'd1;
   localparam logic [1:0] ERR_ROW    = 2'd2;
   localparam logic [1:0] ERR_MATRIX = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS   = 1'd1;

   localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 3'd1;
   localparam logic [NC_W-1:0] NUM_COLS_RST   = 11'd1024;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [COL_W-1:0]        column;
      logic [ELEM_W-1:0]       elem;
      logic signed [VAL_W-1:0] value_re;
      logic signed [VAL_W-1:0] value_im;
   } req_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [POSO_W-1:0]       position;
      logic [COL_W-1:0]        out_column;
      logic [ELEM_W-1:0]       out_elem;
      logic signed [VAL_W-1:0] sum_re;
      logic signed [VAL_W-1:0] sum_im;
      logic                    accumulated;
      logic [1:0]              err_code;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic sweep;
      logic rd_store;
      logic acc;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic to_data;
      logic is_clear;
      logic sweep_done;
      logic out_free;
   } ctrl_stat_type;

endpackage

FILE: rtl/sbrua_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbrua_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                             clock,
   input  logic                                             wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                                 wr_data,
   input  logic                                             rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sbrua_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the row union adder: steps one beat through decode, store
// read-modify-write and result load; runs the column table sweep. Uses sbrua_pkg.
module sbrua_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sbrua_pkg::ctrl_stat_type stat,
   output sbrua_pkg::ctrl_cmd_type  cmd
);

   import sbrua_pkg::*;

   state_type state_ff, state_in;
   logic      clr_emit_ff, clr_emit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         clr_emit_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_emit_ff <= clr_emit_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_emit_in = clr_emit_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in    = clr_emit_ff ? ST_EMIT : ST_IDLE;
               clr_emit_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            priority if (stat.is_clear) begin
               state_in    = ST_SWEEP;
               clr_emit_in = 1'b1;
            end else if (stat.to_data) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_READ: begin
            cmd.rd_store = 1'b1;
            state_in     = ST_ADD;
         end
         ST_ADD: begin
            cmd.acc  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_read_after_decode: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $past(state_ff) == ST_DECODE)
      else $error("store read not preceded by decode");

   a_add_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(state_ff) == ST_READ)
      else $error("accumulate not preceded by store read");

   a_no_pending_clear_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !clr_emit_ff)
      else $error("clear answer still pending while idle");

endmodule

FILE: rtl/sbrua_dp.sv
`timescale 1ns / 1ps
// Datapath of the row union adder: config registers, column table, row value
// store, row bookkeeping, saturating adder and output register. Uses sbrua_pkg, sbrua_ram.
module sbrua_dp #(
   parameter int MAX_COLS        = 1024,
   parameter int ROW_SLOTS       = 64,
   parameter int MAX_BLOCK_ELEMS = 16,
   parameter int MAX_NNZ         = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [sbrua_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbrua_pkg::CSR_DAT_W-1:0]       csr_wdata,
   input  sbrua_pkg::req_type                    req_payload,
   input  sbrua_pkg::ctrl_cmd_type               cmd,
   output sbrua_pkg::ctrl_stat_type              stat,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output sbrua_pkg::rsp_type                    rsp_payload
);

   import sbrua_pkg::*;

   localparam int POS_W    = $clog2(MAX_NNZ + 1);
   localparam int CA_W     = $clog2(MAX_COLS);
   localparam int ST_DEPTH = ROW_SLOTS * MAX_BLOCK_ELEMS;
   localparam int SA_W     = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
   localparam int LS_W     = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
   localparam int EC_W     = 7;

   // config
   logic [BS_W-1:0] blk_ff, blk_in;
   logic [NC_W-1:0] ncols_ff, ncols_in;

   // row and block bookkeeping
   logic [POS_W-1:0] next_pos_ff, next_pos_in;
   logic [POS_W-1:0] row_base_ff, row_base_in;
   logic [POS_W-1:0] cur_slot_ff, cur_slot_in;
   logic [LS_W-1:0]  cur_local_ff, cur_local_in;
   logic             cur_new_ff, cur_new_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [CA_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   req_type          in_ff, in_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [SA_W-1:0]  idx_ff, idx_in;

   // column table and store ports
   logic             tbl_we;
   logic [CA_W-1:0]  tbl_wa;
   logic [POS_W:0]   tbl_wd;
   logic [POS_W:0]   tbl_rd;
   logic [2*VAL_W-1:0] st_wd;
   logic [2*VAL_W-1:0] st_rd;

   // decode terms
   logic [5:0]       sq;
   logic [EC_W-1:0]  elems;
   logic             range_err;
   logic             first;
   logic             tbl_valid;
   logic [POS_W-1:0] tbl_pos;
   logic             fresh;
   logic [POS_W-1:0] used;
   logic [POS_W-1:0] old_off;
   logic             mat_full;
   logic             row_full;
   logic [1:0]       blk_err;

   // adder
   logic signed [VAL_W:0]   sum_re_w, sum_im_w;
   logic signed [VAL_W-1:0] sat_re, sat_im;

   sbrua_ram #(.WIDTH(POS_W + 1), .DEPTH(MAX_COLS)) u_col_tbl (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_en   (cmd.capture),
      .rd_addr (CA_W'(req_payload.column)),
      .rd_data (tbl_rd)
   );

   sbrua_ram #(.WIDTH(2 * VAL_W), .DEPTH(ST_DEPTH)) u_row_store (
      .clock   (clock),
      .wr_en   (cmd.acc),
      .wr_addr (idx_ff),
      .wr_data (st_wd),
      .rd_en   (cmd.rd_store),
      .rd_addr (idx_in),
      .rd_data (st_rd)
   );

   always_comb begin
      sq    = {3'b000, blk_ff} * {3'b000, blk_ff};
      elems = (EC_W'(sq) > EC_W'(MAX_BLOCK_ELEMS)) ? EC_W'(MAX_BLOCK_ELEMS) : EC_W'(sq);
      first = (in_ff.elem == '0);
      range_err = ({1'b0, in_ff.column} >= ncols_ff)
               || (32'(in_ff.column) >= 32'(MAX_COLS))
               || ({3'b000, in_ff.elem} >= elems)
               || (!first && !cur_valid_ff);
      tbl_valid = tbl_rd[POS_W];
      tbl_pos   = tbl_rd[POS_W-1:0];
      fresh     = (in_ff.cmd == CMD_A) || !tbl_valid || (tbl_pos < row_base_ff);
      used      = next_pos_ff - row_base_ff;
      old_off   = tbl_pos - row_base_ff;
      mat_full  = 32'(next_pos_ff) >= 32'(MAX_NNZ);
      row_full  = 32'(used) >= 32'(ROW_SLOTS);
      priority if (range_err) begin
         blk_err = ERR_RANGE;
      end else if (first && fresh && mat_full) begin
         blk_err = ERR_MATRIX;
      end else if (first && fresh && row_full) begin
         blk_err = ERR_ROW;
      end else begin
         blk_err = ERR_NONE;
      end
   end

   always_comb begin
      sum_re_w = {st_rd[2*VAL_W-1], st_rd[2*VAL_W-1:VAL_W]}
               + {in_ff.value_re[VAL_W-1], in_ff.value_re};
      sum_im_w = {st_rd[VAL_W-1], st_rd[VAL_W-1:0]}
               + {in_ff.value_im[VAL_W-1], in_ff.value_im};
      if (sum_re_w[VAL_W] != sum_re_w[VAL_W-1]) begin
         sat_re = sum_re_w[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         sat_re = sum_re_w[VAL_W-1:0];
      end
      if (sum_im_w[VAL_W] != sum_im_w[VAL_W-1]) begin
         sat_im = sum_im_w[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         sat_im = sum_im_w[VAL_W-1:0];
      end
      if (cur_new_ff) begin
         st_wd = {in_ff.value_re, in_ff.value_im};
      end else begin
         st_wd = {sat_re, sat_im};
      end
   end

   always_comb begin
      blk_in       = blk_ff;
      ncols_in     = ncols_ff;
      next_pos_in  = next_pos_ff;
      row_base_in  = row_base_ff;
      cur_slot_in  = cur_slot_ff;
      cur_local_in = cur_local_ff;
      cur_new_in   = cur_new_ff;
      cur_valid_in = cur_valid_ff;
      cur_col_in   = cur_col_ff;
      sweep_cnt_in = sweep_cnt_ff;
      in_in        = in_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      tbl_we       = 1'b0;
      tbl_wa       = CA_W'(in_ff.column);
      tbl_wd       = {1'b1, next_pos_ff};

      if (csr_wr_en) begin
         if (csr_index == CSR_BLOCK_SIZE) begin
            blk_in = csr_wdata[BS_W-1:0];
         end else if (csr_index == CSR_NUM_COLS) begin
            ncols_in = csr_wdata[NC_W-1:0];
         end
      end

      if (cmd.capture) begin
         in_in = req_payload;
      end

      if (cmd.sweep) begin
         tbl_we       = 1'b1;
         tbl_wa       = sweep_cnt_ff;
         tbl_wd       = '0;
         sweep_cnt_in = stat.sweep_done ? '0 : sweep_cnt_ff + CA_W'(1);
      end

      if (cmd.decode) begin
         unique case (in_ff.cmd)
            CMD_CLEAR: begin
               next_pos_in  = '0;
               row_base_in  = '0;
               cur_valid_in = 1'b0;
               res_in       = '0;
               res_in.kind  = KIND_ROW_END;
            end
            CMD_ROW_END: begin
               row_base_in     = next_pos_ff;
               cur_valid_in    = 1'b0;
               res_in          = '0;
               res_in.kind     = KIND_ROW_END;
               res_in.position = POSO_W'(next_pos_ff);
            end
            CMD_A, CMD_B: begin
               if (blk_err != ERR_NONE) begin
                  if (first) begin
                     cur_valid_in = 1'b0;
                  end
                  res_in            = '0;
                  res_in.kind       = KIND_ERROR;
                  res_in.out_column = in_ff.column;
                  res_in.out_elem   = in_ff.elem;
                  res_in.err_code   = blk_err;
               end else if (first) begin
                  cur_valid_in = 1'b1;
                  cur_col_in   = in_ff.column;
                  cur_new_in   = fresh;
                  if (fresh) begin
                     tbl_we       = 1'b1;
                     cur_slot_in  = next_pos_ff;
                     cur_local_in = LS_W'(used);
                     next_pos_in  = next_pos_ff + POS_W'(1);
                  end else begin
                     cur_slot_in  = tbl_pos;
                     cur_local_in = LS_W'(old_off);
                  end
               end
            end
         endcase
      end

      if (cmd.rd_store) begin
         idx_in = SA_W'(cur_local_ff) * SA_W'(MAX_BLOCK_ELEMS) + SA_W'(in_ff.elem);
      end

      if (cmd.acc) begin
         res_in.kind        = KIND_DATA;
         res_in.position    = POSO_W'(cur_slot_ff);
         res_in.out_column  = cur_col_ff;
         res_in.out_elem    = in_ff.elem;
         res_in.sum_re      = st_wd[2*VAL_W-1:VAL_W];
         res_in.sum_im      = st_wd[VAL_W-1:0];
         res_in.accumulated = !cur_new_ff;
         res_in.err_code    = ERR_NONE;
      end

      if (cmd.emit) begin
         rsp_data_in = res_ff;
      end

      rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff       <= BLOCK_SIZE_RST;
         ncols_ff     <= NUM_COLS_RST;
         next_pos_ff  <= '0;
         row_base_ff  <= '0;
         cur_slot_ff  <= '0;
         cur_local_ff <= '0;
         cur_new_ff   <= 1'b0;
         cur_valid_ff <= 1'b0;
         cur_col_ff   <= '0;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         blk_ff       <= blk_in;
         ncols_ff     <= ncols_in;
         next_pos_ff  <= next_pos_in;
         row_base_ff  <= row_base_in;
         cur_slot_ff  <= cur_slot_in;
         cur_local_ff <= cur_local_in;
         cur_new_ff   <= cur_new_in;
         cur_valid_ff <= cur_valid_in;
         cur_col_ff   <= cur_col_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= idx_in;
   end

   assign stat.to_data    = ((in_ff.cmd == CMD_A) || (in_ff.cmd == CMD_B))
                          && (blk_err == ERR_NONE);
   assign stat.is_clear   = (in_ff.cmd == CMD_CLEAR);
   assign stat.sweep_done = (sweep_cnt_ff == CA_W'(MAX_COLS - 1));
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      row_base_ff <= next_pos_ff)
      else $error("row start beyond next position");

   a_row_capacity: assert property (@(posedge clock) disable iff (reset)
      (32'(next_pos_ff - row_base_ff) <= 32'(ROW_SLOTS))
      && (32'(next_pos_ff) <= 32'(MAX_NNZ)))
      else $error("row or matrix capacity exceeded");

   a_open_block_in_row: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_slot_ff >= row_base_ff) && (cur_slot_ff < next_pos_ff))
      else $error("open block outside the current row");

endmodule

FILE: rtl/sparse_block_row_union_add.sv
`timescale 1ns / 1ps
// Top level of the block-sparse row union adder (C = A + B, streamed by element).
// Uses sbrua_pkg, sbrua_ctrl, sbrua_dp (with sbrua_ram inside).
//
//   port group   dir  handshake             beat
//   req_*        in   req_valid/req_stall   sbrua_pkg::req_type
//   rsp_*        out  rsp_valid/rsp_stall   sbrua_pkg::rsp_type
//   csr_*        in   csr_wr_en             csr_index, csr_wdata
//
// An element beat steps from accept to the next accept through table read,
// slot index, store read, saturating add into the store and output load; the
// row value store's read-modify-write sets this sequence. Row end and error
// beats skip the store steps; clear adds a column table sweep.
// After reset the column table is swept; req_stall stays high meanwhile.
// The output register frees the input side while a result waits on rsp_stall.
module sparse_block_row_union_add #(
   parameter int MAX_COLS        = 1024,
   parameter int ROW_SLOTS       = 64,
   parameter int MAX_BLOCK_ELEMS = 16,
   parameter int MAX_NNZ         = 65536
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sbrua_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sbrua_pkg::rsp_type              rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [sbrua_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbrua_pkg::CSR_DAT_W-1:0] csr_wdata
);

   import sbrua_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   sbrua_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbrua_dp #(
      .MAX_COLS        (MAX_COLS),
      .ROW_SLOTS       (ROW_SLOTS),
      .MAX_BLOCK_ELEMS (MAX_BLOCK_ELEMS),
      .MAX_NNZ         (MAX_NNZ)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
